/* design/route_table_prefix_forwarder_macros.svh */
// Assertion helpers for the route table forwarder
`ifndef ROUTE_TABLE_PREFIX_FORWARDER_MACROS_SVH
`define ROUTE_TABLE_PREFIX_FORWARDER_MACROS_SVH
`ifndef SYNTHESIS
`define RTPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("route table assertion failed");
`define RTPF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("route table assertion failed");
`else
`define RTPF_ASSERT(lbl, prop)
`define RTPF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* design/rtpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rtpf_pkg;
  localparam logic [1:0] OP_ADVERT   = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_REGISTER = 2'd2;

  localparam logic [2:0] ACT_IGNORED      = 3'd0;
  localparam logic [2:0] ACT_RELAY        = 3'd1;
  localparam logic [2:0] ACT_FORWARD      = 3'd2;
  localparam logic [2:0] ACT_DELIVER      = 3'd3;
  localparam logic [2:0] ACT_NO_NEIGHBOUR = 3'd4;
  localparam logic [2:0] ACT_FULL         = 3'd5;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_en;
    logic sel_switch;
    logic finish;
  } rtpf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic adapter_hit;
  } rtpf_status_t;

  function automatic logic [5:0] common_prefix(input logic [31:0] diff);
    logic [5:0] n;
    logic       stop;
    n    = 6'd32;
    stop = 1'b0;
    for (int b = 31; b >= 0; b--) begin
      if (!stop && diff[b]) begin
        n    = 6'(31 - b);
        stop = 1'b1;
      end
    end
    return n;
  endfunction
endpackage
`default_nettype wire

/* design/rtpf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtpf_ctrl
  import rtpf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [1:0]   op_i,
  input  rtpf_status_t      status_i,
  output rtpf_cmd_t         cmd_o,
  output logic              busy_o
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ASCAN  = 2'd1;
  localparam logic [1:0] S_SSCAN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          if (op_i == OP_LOOKUP) state_d = S_ASCAN;
          else if (op_i == OP_ADVERT) state_d = S_SSCAN;
          else state_d = S_FINISH;
        end
      end
      S_ASCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          if (status_i.adapter_hit) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = S_SSCAN;
          end
        end
      end
      S_SSCAN: begin
        cmd_o.scan_en    = 1'b1;
        cmd_o.sel_switch = 1'b1;
        if (status_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

/* design/rtpf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtpf_datapath
  import rtpf_pkg::*;
#(
  parameter int SWITCH_ENTRIES  = 32,
  parameter int ADAPTER_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  rtpf_cmd_t        cmd_i,
  output rtpf_status_t     status_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] ip_i,
  input  wire logic [31:0] distance_i,
  input  wire logic [3:0]  port_i,
  output logic             done_o,
  output logic [2:0]       action_o,
  output logic [3:0]       out_port_o,
  output logic [31:0]      route_ip_o,
  output logic [31:0]      route_distance_o,
  output logic [5:0]       prefix_bits_o
);
  localparam int SW_AW  = $clog2(SWITCH_ENTRIES);
  localparam int AD_AW  = (ADAPTER_ENTRIES > 1) ? $clog2(ADAPTER_ENTRIES) : 1;
  localparam int SW_CW  = $clog2(SWITCH_ENTRIES + 1);
  localparam int AD_CW  = $clog2(ADAPTER_ENTRIES + 1);
  localparam int MAXE   = (SWITCH_ENTRIES > ADAPTER_ENTRIES) ? SWITCH_ENTRIES
                                                             : ADAPTER_ENTRIES;
  localparam int IDX_W  = $clog2(MAXE + 1);

  logic [31:0] sw_ip_mem   [SWITCH_ENTRIES];
  logic [31:0] sw_dist_mem [SWITCH_ENTRIES];
  logic [3:0]  sw_port_mem [SWITCH_ENTRIES];
  logic [3:0]  sw_home_mem [SWITCH_ENTRIES];
  logic [31:0] ad_ip_mem   [ADAPTER_ENTRIES];
  logic [3:0]  ad_port_mem [ADAPTER_ENTRIES];

  logic [1:0]  op_q;
  logic [31:0] ip_q, dist_q;
  logic [3:0]  port_q;
  logic [SW_CW-1:0] scount_q;
  logic [AD_CW-1:0] acount_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] limit;
  logic             rd_vld_q, rd_sel_q;
  logic [SW_AW-1:0] rd_idx_q;
  logic [31:0] rd_sip_q, rd_sdist_q, rd_aip_q;
  logic [3:0]  rd_sport_q, rd_shome_q, rd_aport_q;
  logic        a_hit_q, s_hit_q;
  logic [3:0]  a_port_q, best_port_q;
  logic [5:0]  best_len_q, len;
  logic [SW_AW-1:0] hit_idx_q;
  logic [31:0] hit_dist_q;
  logic        issue;
  logic        sw_we, home_we, ad_we;
  logic [SW_AW-1:0] sw_wa;
  logic [AD_AW-1:0] ad_wa;
  logic [2:0]  act_d;
  logic [3:0]  oport_d;
  logic [31:0] rip_d, rdist_d;
  logic [5:0]  bits_d;

  assign limit = cmd_i.sel_switch ? IDX_W'(scount_q) : IDX_W'(acount_q);
  assign issue = cmd_i.scan_en && (idx_q < limit);
  assign status_o.scan_done   = cmd_i.scan_en && !issue && !rd_vld_q;
  assign status_o.adapter_hit = a_hit_q;
  assign len = common_prefix(rd_sip_q ^ ip_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      ip_q   <= ip_i;
      dist_q <= distance_i;
      port_q <= port_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sip_q   <= sw_ip_mem[idx_q[SW_AW-1:0]];
    rd_sdist_q <= sw_dist_mem[idx_q[SW_AW-1:0]];
    rd_sport_q <= sw_port_mem[idx_q[SW_AW-1:0]];
    rd_shome_q <= sw_home_mem[idx_q[SW_AW-1:0]];
    rd_aip_q   <= ad_ip_mem[idx_q[AD_AW-1:0]];
    rd_aport_q <= ad_port_mem[idx_q[AD_AW-1:0]];
    rd_idx_q   <= idx_q[SW_AW-1:0];
    rd_sel_q   <= cmd_i.sel_switch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (issue) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q <= 1'b0;
      s_hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      a_hit_q <= 1'b0;
      s_hit_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (!rd_sel_q) begin
        if (!a_hit_q && rd_aip_q == ip_q) a_hit_q <= 1'b1;
      end else if (op_q == OP_ADVERT) begin
        if (!s_hit_q && rd_sip_q == ip_q) s_hit_q <= 1'b1;
      end else if (rd_sport_q == rd_shome_q && (!s_hit_q || len > best_len_q)) begin
        s_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (!rd_sel_q) begin
        if (!a_hit_q && rd_aip_q == ip_q) a_port_q <= rd_aport_q;
      end else if (op_q == OP_ADVERT) begin
        if (!s_hit_q && rd_sip_q == ip_q) begin
          hit_idx_q  <= rd_idx_q;
          hit_dist_q <= rd_sdist_q;
        end
      end else if (rd_sport_q == rd_shome_q && (!s_hit_q || len > best_len_q)) begin
        best_len_q  <= len;
        best_port_q <= rd_sport_q;
      end
    end
  end

  always_comb begin
    sw_we   = 1'b0;
    home_we = 1'b0;
    ad_we   = 1'b0;
    sw_wa   = hit_idx_q;
    ad_wa   = acount_q[AD_AW-1:0];
    act_d   = ACT_IGNORED;
    oport_d = '0;
    rip_d   = '0;
    rdist_d = '0;
    bits_d  = '0;
    case (op_q)
      OP_ADVERT: begin
        if (s_hit_q) begin
          if (dist_q < hit_dist_q) begin
            sw_we   = 1'b1;
            act_d   = ACT_RELAY;
            oport_d = port_q;
            rip_d   = ip_q;
            rdist_d = dist_q;
          end
        end else if (scount_q == SW_CW'(SWITCH_ENTRIES)) begin
          act_d = ACT_FULL;
        end else begin
          sw_we   = 1'b1;
          home_we = 1'b1;
          sw_wa   = scount_q[SW_AW-1:0];
          act_d   = ACT_RELAY;
          oport_d = port_q;
          rip_d   = ip_q;
          rdist_d = dist_q;
        end
      end
      OP_LOOKUP: begin
        if (a_hit_q) begin
          act_d   = ACT_DELIVER;
          oport_d = a_port_q;
        end else if (s_hit_q) begin
          act_d   = ACT_FORWARD;
          oport_d = best_port_q;
          bits_d  = best_len_q;
        end else begin
          act_d = ACT_NO_NEIGHBOUR;
        end
      end
      OP_REGISTER: begin
        if (acount_q == AD_CW'(ADAPTER_ENTRIES)) act_d = ACT_FULL;
        else ad_we = 1'b1;
      end
      default: act_d = ACT_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && sw_we) begin
      sw_ip_mem[sw_wa]   <= ip_q;
      sw_dist_mem[sw_wa] <= dist_q;
      sw_port_mem[sw_wa] <= port_q;
    end
    if (cmd_i.finish && home_we) sw_home_mem[sw_wa] <= port_q;
    if (cmd_i.finish && ad_we) begin
      ad_ip_mem[ad_wa]   <= ip_q;
      ad_port_mem[ad_wa] <= port_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scount_q <= '0;
      acount_q <= '0;
      done_o   <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cmd_i.finish && home_we) scount_q <= scount_q + 1'b1;
      if (cmd_i.finish && ad_we) acount_q <= acount_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      action_o         <= act_d;
      out_port_o       <= oport_d;
      route_ip_o       <= rip_d;
      route_distance_o <= rdist_d;
      prefix_bits_o    <= bits_d;
    end
  end
endmodule
`default_nettype wire

/* design/route_table_prefix_forwarder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Route table engine: one request at a time, taken when start_i is high and
// busy_o low. The single result appears for one cycle with done_o high and
// cannot be held off, so capture it then. A request walks its table one entry
// per cycle through registered-read memories: an advert walks the switch
// table, an adapter register walks no table, and a lookup walks the adapter
// table and then the switch table unless the adapter table hits. done_o goes
// high in the same cycle as busy_o goes low.
`include "route_table_prefix_forwarder_macros.svh"
module route_table_prefix_forwarder
  import rtpf_pkg::*;
#(
  parameter int SWITCH_ENTRIES  = 32,
  parameter int ADAPTER_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] ip_i,
  input  wire logic [31:0] distance_i,
  input  wire logic [31:0] neighbour_ip_i,
  input  wire logic [3:0]  port_i,
  output logic             done_o,
  output logic [2:0]       action_o,
  output logic [3:0]       out_port_o,
  output logic [31:0]      route_ip_o,
  output logic [31:0]      route_distance_o,
  output logic [5:0]       prefix_bits_o
);
  rtpf_cmd_t    cmd;
  rtpf_status_t status;
  logic         nip_unused;

  assign nip_unused = ^neighbour_ip_i;

  rtpf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (op_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  rtpf_datapath #(
    .SWITCH_ENTRIES  (SWITCH_ENTRIES),
    .ADAPTER_ENTRIES (ADAPTER_ENTRIES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .op_i             (op_i),
    .ip_i             (ip_i),
    .distance_i       (distance_i),
    .port_i           (port_i),
    .done_o           (done_o),
    .action_o         (action_o),
    .out_port_o       (out_port_o),
    .route_ip_o       (route_ip_o),
    .route_distance_o (route_distance_o),
    .prefix_bits_o    (prefix_bits_o)
  );

  `RTPF_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `RTPF_ASSERT(a_done_idle, done_o |-> !busy_o)
  `RTPF_ASSERT(a_action_range, done_o |-> (action_o <= ACT_FULL))
  `RTPF_ASSERT(a_prefix_range, (done_o && action_o == ACT_FORWARD) |-> (prefix_bits_o <= 6'd32))
  `RTPF_ASSERT(a_relay_fields, (done_o && action_o != ACT_RELAY) |-> (route_ip_o == 32'd0))
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import rtpf_pkg::*;

  localparam int SWITCH_DEPTH  = 32;
  localparam int ADAPTER_DEPTH = 16;
  localparam int RANDOM_ITEMS  = 1330;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ip;
    logic [31:0] distance;
    logic [31:0] neighbour_ip;
    logic [3:0]  port;
    bit          drain;
  } request_t;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  out_port;
    logic [31:0] route_ip;
    logic [31:0] route_distance;
    logic [5:0]  prefix_bits;
  } route_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [31:0] ip_i;
  logic [31:0] distance_i;
  logic [31:0] neighbour_ip_i;
  logic [3:0]  port_i;
  logic        done_o;
  logic [2:0]  action_o;
  logic [3:0]  out_port_o;
  logic [31:0] route_ip_o;
  logic [31:0] route_distance_o;
  logic [5:0]  prefix_bits_o;

  route_table_prefix_forwarder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .ip_i             (ip_i),
    .distance_i       (distance_i),
    .neighbour_ip_i   (neighbour_ip_i),
    .port_i           (port_i),
    .done_o           (done_o),
    .action_o         (action_o),
    .out_port_o       (out_port_o),
    .route_ip_o       (route_ip_o),
    .route_distance_o (route_distance_o),
    .prefix_bits_o    (prefix_bits_o)
  );

  request_t      pending_requests[$];
  route_result_t expected_routes[$];
  int            total_requests;
  int            sent_cnt;
  int            taken_cnt;
  int            error_cnt;

  logic [31:0] sw_ip[SWITCH_DEPTH];
  logic [31:0] sw_distance[SWITCH_DEPTH];
  logic [31:0] sw_next_hop[SWITCH_DEPTH];
  logic [3:0]  sw_port[SWITCH_DEPTH];
  logic [3:0]  sw_home_port[SWITCH_DEPTH];
  int          sw_count;
  logic [31:0] ad_ip[ADAPTER_DEPTH];
  logic [3:0]  ad_port[ADAPTER_DEPTH];
  int          ad_count;

  logic [31:0] addr_pool[48];
  logic [31:0] adapter_addrs[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [5:0] prefix_len(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    int          n;
    diff = a ^ b;
    n = 0;
    while (n < 32 && !diff[31 - n]) n++;
    return 6'(n);
  endfunction

  function automatic route_result_t forward_route(request_t rq);
    route_result_t r;
    bit            found;
    logic [5:0]    best_len;
    logic [5:0]    len;
    r = '{ACT_IGNORED, 4'd0, 32'd0, 32'd0, 6'd0};
    found = 0;
    best_len = 6'd0;
    case (rq.op)
      OP_ADVERT: begin
        for (int i = 0; i < sw_count; i++) begin
          if (sw_ip[i] == rq.ip) begin
            if (rq.distance >= sw_distance[i]) return r;
            sw_distance[i] = rq.distance;
            sw_next_hop[i] = rq.neighbour_ip;
            sw_port[i] = rq.port;
            r = '{ACT_RELAY, rq.port, rq.ip, rq.distance, 6'd0};
            return r;
          end
        end
        if (sw_count >= SWITCH_DEPTH) begin
          r.action = ACT_FULL;
          return r;
        end
        sw_ip[sw_count] = rq.ip;
        sw_distance[sw_count] = rq.distance;
        sw_next_hop[sw_count] = rq.neighbour_ip;
        sw_port[sw_count] = rq.port;
        sw_home_port[sw_count] = rq.port;
        sw_count++;
        r = '{ACT_RELAY, rq.port, rq.ip, rq.distance, 6'd0};
      end
      OP_LOOKUP: begin
        for (int i = 0; i < ad_count; i++) begin
          if (ad_ip[i] == rq.ip) begin
            r.action = ACT_DELIVER;
            r.out_port = ad_port[i];
            return r;
          end
        end
        for (int i = 0; i < sw_count; i++) begin
          if (sw_port[i] == sw_home_port[i]) begin
            len = prefix_len(sw_ip[i], rq.ip);
            if (!found || len > best_len) begin
              found = 1;
              best_len = len;
              r.out_port = sw_port[i];
            end
          end
        end
        if (!found) r.action = ACT_NO_NEIGHBOUR;
        else begin
          r.action = ACT_FORWARD;
          r.prefix_bits = best_len;
        end
      end
      OP_REGISTER: begin
        if (ad_count >= ADAPTER_DEPTH) r.action = ACT_FULL;
        else begin
          ad_ip[ad_count] = rq.ip;
          ad_port[ad_count] = rq.port;
          ad_count++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_request(logic [1:0] op, logic [31:0] ip, logic [31:0] dist_val,
                                       logic [31:0] nip, logic [3:0] port, bit drain);
    request_t rq;
    rq = '{op, ip, dist_val, nip, port, drain};
    pending_requests.push_back(rq);
    if (op == OP_REGISTER) adapter_addrs.push_back(ip);
  endfunction

  function automatic logic [31:0] lookup_addr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20 && adapter_addrs.size() != 0)
      return adapter_addrs[$urandom_range(adapter_addrs.size() - 1)];
    if (sel < 80)
      return addr_pool[$urandom_range(47)] ^ ($urandom >> $urandom_range(31));
    return $urandom;
  endfunction

  always @(negedge clk_i) begin
    int idle_pct;
    request_t rq;
    idle_pct = (taken_cnt < total_requests / 3) ? 23 :
               (taken_cnt < 2 * total_requests / 3) ? 81 : 0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && sent_cnt != taken_cnt) begin
    end else if (pending_requests.size() == 0 || $urandom_range(99) < idle_pct ||
                 (pending_requests[0].drain && expected_routes.size() != 0)) begin
      start_i <= 1'b0;
    end else begin
      rq = pending_requests.pop_front();
      op_i <= rq.op;
      ip_i <= rq.ip;
      distance_i <= rq.distance;
      neighbour_ip_i <= rq.neighbour_ip;
      port_i <= rq.port;
      start_i <= 1'b1;
      sent_cnt++;
    end
  end

  always @(posedge clk_i) begin
    route_result_t exp_r;
    request_t rq;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_routes.size() == 0) begin
          $error("result with no request outstanding: action %0d", action_o);
          error_cnt++;
        end else begin
          exp_r = expected_routes.pop_front();
          if (action_o !== exp_r.action) begin
            $error("action: expected %0d, got %0d", exp_r.action, action_o);
            error_cnt++;
          end
          if (out_port_o !== exp_r.out_port) begin
            $error("out_port: expected %0d, got %0d", exp_r.out_port, out_port_o);
            error_cnt++;
          end
          if (route_ip_o !== exp_r.route_ip) begin
            $error("route_ip: expected %h, got %h", exp_r.route_ip, route_ip_o);
            error_cnt++;
          end
          if (route_distance_o !== exp_r.route_distance) begin
            $error("route_distance: expected %h, got %h", exp_r.route_distance,
                   route_distance_o);
            error_cnt++;
          end
          if (prefix_bits_o !== exp_r.prefix_bits) begin
            $error("prefix_bits: expected %0d, got %0d", exp_r.prefix_bits, prefix_bits_o);
            error_cnt++;
          end
        end
      end
      if (start_i && !busy_o) begin
        rq = '{op_i, ip_i, distance_i, neighbour_ip_i, port_i, 1'b0};
        expected_routes.push_back(forward_route(rq));
        taken_cnt++;
      end
    end
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int sel;
    start_i = 1'b0;
    op_i = OP_ADVERT;
    ip_i = '0;
    distance_i = '0;
    neighbour_ip_i = '0;
    port_i = '0;
    rst_ni = 1'b0;
    sent_cnt = 0;
    taken_cnt = 0;
    error_cnt = 0;
    sw_count = 0;
    ad_count = 0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;

    push_request(OP_LOOKUP, 32'h0a000001, '0, '0, 4'd0, 0);
    push_request(OP_REGISTER, 32'hc0a80001, '0, '0, 4'd15, 0);
    push_request(OP_LOOKUP, 32'hc0a80001, '0, '0, 4'd0, 0);
    push_request(OP_ADVERT, 32'h0a000000, 32'd100, 32'hffffffff, 4'd3, 0);
    push_request(OP_ADVERT, 32'h0a000000, 32'd100, 32'h1, 4'd4, 0);
    push_request(OP_ADVERT, 32'h0a000000, 32'hffffffff, 32'h1, 4'd4, 0);
    push_request(OP_LOOKUP, 32'h0a0000ff, '0, '0, 4'd0, 0);
    push_request(OP_ADVERT, 32'h0a000000, 32'd5, 32'h0, 4'd7, 0);
    push_request(OP_LOOKUP, 32'h0a000000, '0, '0, 4'd0, 0);
    push_request(OP_ADVERT, 32'hffffffff, 32'd0, 32'h0, 4'd15, 0);
    push_request(OP_ADVERT, 32'h00000000, 32'hffffffff, 32'hffffffff, 4'd0, 0);
    push_request(OP_ADVERT, 32'h80000000, 32'd1, 32'h2, 4'd9, 0);
    push_request(OP_LOOKUP, 32'hffffffff, '0, '0, 4'd0, 0);
    push_request(OP_LOOKUP, 32'h00000000, '0, '0, 4'd0, 0);
    push_request(OP_LOOKUP, 32'h7fffffff, '0, '0, 4'd0, 0);
    push_request(OP_LOOKUP, 32'h80000001, '0, '0, 4'd0, 0);
    push_request(OP_REGISTER, 32'hc0a80001, '0, '0, 4'd2, 0);
    push_request(OP_LOOKUP, 32'hc0a80001, '0, '0, 4'd0, 0);
    push_request(OP_UNKNOWN, 32'hffffffff, 32'hffffffff, 32'hffffffff, 4'd15, 0);
    push_request(OP_ADVERT, 32'h12345678, 32'd0, 32'h0, 4'd1, 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 45)
        push_request(OP_ADVERT,
                     ($urandom_range(99) < 85) ? addr_pool[$urandom_range(47)] : $urandom,
                     ($urandom_range(1)) ? $urandom_range(1000) : $urandom,
                     $urandom, 4'($urandom), n == RANDOM_ITEMS / 2);
      else if (sel < 85)
        push_request(OP_LOOKUP, lookup_addr(), $urandom, $urandom, 4'($urandom),
                     n == RANDOM_ITEMS / 2);
      else if (sel < 95)
        push_request(OP_REGISTER,
                     ($urandom_range(1)) ? addr_pool[$urandom_range(47)] : $urandom,
                     $urandom, $urandom, 4'($urandom), n == RANDOM_ITEMS / 2);
      else
        push_request(OP_UNKNOWN, $urandom, $urandom, $urandom, 4'($urandom),
                     n == RANDOM_ITEMS / 2);
    end
    total_requests = pending_requests.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || sent_cnt != taken_cnt ||
           expected_routes.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_cnt == 0 && expected_routes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
